// File: hdl/tprm_pkg.sv
// tprm_pkg: shared types and constants for the touchpad to relative mouse block
// holds the touch point field layout and the flag struct passed front to back
// no dependencies
`default_nettype none

package tprm_pkg;

    // byte 0 bit 7 clear means the finger touches
    localparam int unsigned TOUCH_N_BIT = 7;

    // 12-bit coordinate fields inside a packed point
    localparam int unsigned FIELD_BITS = 12;
    localparam int unsigned X_LSB      = 8;
    localparam int unsigned Y_LSB      = 20;

    // widest coordinate the block supports
    localparam int unsigned COORD_MAX_BITS = 16;

    localparam int unsigned LIMIT_BITS = 7;
    localparam int unsigned DELTA_BITS = 8;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 7'd127;

    typedef struct packed {
        logic touch;
        logic click;
        logic host_ready;
    } point_flags_t;

endpackage

`default_nettype wire

// File: hdl/tprm_front.sv
// tprm_front: decodes the two packed touch points and picks the active finger
// depends on tprm_pkg
`default_nettype none

module tprm_front #(
    parameter int unsigned COORD_BITS = 12
) (
    input  wire logic [31:0]            point0_raw,
    input  wire logic [31:0]            point1_raw,
    input  wire logic                   click,
    input  wire logic                   host_ready,
    output tprm_pkg::point_flags_t      flags,
    output logic      [COORD_BITS-1:0]  pos_x,
    output logic      [COORD_BITS-1:0]  pos_y
);

    logic                                 touch0;
    logic                                 touch1;
    logic [tprm_pkg::COORD_MAX_BITS-1:0]  x0_wide;
    logic [tprm_pkg::COORD_MAX_BITS-1:0]  y0_wide;
    logic [tprm_pkg::COORD_MAX_BITS-1:0]  x1_wide;
    logic [tprm_pkg::COORD_MAX_BITS-1:0]  y1_wide;

    localparam int unsigned PAD_BITS = tprm_pkg::COORD_MAX_BITS - tprm_pkg::FIELD_BITS;

    assign touch0 = ~point0_raw[tprm_pkg::TOUCH_N_BIT];
    assign touch1 = ~point1_raw[tprm_pkg::TOUCH_N_BIT];

    // fields are 12 bits; narrower coordinates drop the top bits
    assign x0_wide = {{PAD_BITS{1'b0}}, point0_raw[tprm_pkg::X_LSB +: tprm_pkg::FIELD_BITS]};
    assign y0_wide = {{PAD_BITS{1'b0}}, point0_raw[tprm_pkg::Y_LSB +: tprm_pkg::FIELD_BITS]};
    assign x1_wide = {{PAD_BITS{1'b0}}, point1_raw[tprm_pkg::X_LSB +: tprm_pkg::FIELD_BITS]};
    assign y1_wide = {{PAD_BITS{1'b0}}, point1_raw[tprm_pkg::Y_LSB +: tprm_pkg::FIELD_BITS]};

    always_comb
    begin
        flags.touch      = touch0 | touch1;
        flags.click      = click;
        flags.host_ready = host_ready;
        if (touch0)
        begin
            pos_x = x0_wide[COORD_BITS-1:0];
            pos_y = y0_wide[COORD_BITS-1:0];
        end
        else
        begin
            pos_x = x1_wide[COORD_BITS-1:0];
            pos_y = y1_wide[COORD_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

// File: hdl/tprm_queue.sv
// tprm_queue: two-entry queue between the decode front and the tracking back
// no package dependencies
`default_nettype none

module tprm_queue #(
    parameter int unsigned DATA_BITS = 27
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire logic [DATA_BITS-1:0] push_data,
    input  wire logic                 pop,
    output logic                      full,
    output logic                      head_valid,
    output logic      [DATA_BITS-1:0] head_data,
    output logic      [1:0]           count
);

    logic [DATA_BITS-1:0] entry_reg [2];
    logic                 wr_ptr_reg;
    logic                 wr_ptr_next;
    logic                 rd_ptr_reg;
    logic                 rd_ptr_next;
    logic [1:0]           count_reg;
    logic [1:0]           count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign full       = count_reg[1];
    assign head_valid = count_reg != 2'd0;
    assign head_data  = entry_reg[rd_ptr_reg];
    assign count      = count_reg;

endmodule

`default_nettype wire

// File: hdl/tprm_back.sv
// tprm_back: anchor tracking, delta saturation and the report output register
// depends on tprm_pkg
`default_nettype none

module tprm_back #(
    parameter int unsigned COORD_BITS = 12
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic      [tprm_pkg::LIMIT_BITS-1:0]   max_delta,
    input  wire logic                                   head_valid,
    input  wire tprm_pkg::point_flags_t                 head_flags,
    input  wire logic      [COORD_BITS-1:0]             head_x,
    input  wire logic      [COORD_BITS-1:0]             head_y,
    output logic                                        pop,
    output logic                                        report_valid,
    input  wire logic                                   report_stall,
    output logic                                        button_state,
    output logic signed    [tprm_pkg::DELTA_BITS-1:0]   delta_x,
    output logic signed    [tprm_pkg::DELTA_BITS-1:0]   delta_y
);

    localparam int unsigned DIFF_BITS = COORD_BITS + 1;
    localparam int unsigned DB        = tprm_pkg::DELTA_BITS;

    logic                    anchor_valid_reg;
    logic                    anchor_valid_next;
    logic [COORD_BITS-1:0]   anchor_x_reg;
    logic [COORD_BITS-1:0]   anchor_x_next;
    logic [COORD_BITS-1:0]   anchor_y_reg;
    logic [COORD_BITS-1:0]   anchor_y_next;
    logic                    prior_touch_reg;
    logic                    prior_touch_next;
    logic                    last_click_reg;
    logic                    last_click_next;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    out_button_reg;
    logic signed [DB-1:0]    out_dx_reg;
    logic signed [DB-1:0]    out_dy_reg;

    logic signed [DIFF_BITS-1:0] limit_pos;
    logic signed [DIFF_BITS-1:0] limit_neg;
    logic signed [DIFF_BITS-1:0] diff_x;
    logic signed [DIFF_BITS-1:0] diff_y;
    logic signed [DB-1:0]        dx;
    logic signed [DB-1:0]        dy;
    logic                        moving;
    logic                        emit;
    logic                        out_free;
    logic                        load;

    function automatic logic signed [DB-1:0] clamp(
        input logic signed [DIFF_BITS-1:0] v,
        input logic signed [DIFF_BITS-1:0] hi,
        input logic signed [DIFF_BITS-1:0] lo
    );
        logic signed [DIFF_BITS-1:0] r;
        if (v > hi)
        begin
            r = hi;
        end
        else if (v < lo)
        begin
            r = lo;
        end
        else
        begin
            r = v;
        end
        return r[DB-1:0];
    endfunction

    always_comb
    begin
        limit_pos = DIFF_BITS'(max_delta);
        limit_neg = -limit_pos;
        diff_x    = $signed({1'b0, head_x}) - $signed({1'b0, anchor_x_reg});
        diff_y    = $signed({1'b0, head_y}) - $signed({1'b0, anchor_y_reg});
        moving    = head_flags.touch & prior_touch_reg & anchor_valid_reg;
        if (moving)
        begin
            dx = clamp(diff_x, limit_pos, limit_neg);
            dy = clamp(diff_y, limit_pos, limit_neg);
        end
        else
        begin
            dx = '0;
            dy = '0;
        end
        emit     = head_flags.host_ready &
                   ((dx != '0) | (dy != '0) | (head_flags.click != last_click_reg));
        out_free = ~out_valid_reg | ~report_stall;
        // a transaction with no report never waits for the output side
        pop      = head_valid & (~emit | out_free);
        load     = pop & emit;
    end

    always_comb
    begin
        anchor_valid_next = anchor_valid_reg;
        anchor_x_next     = anchor_x_reg;
        anchor_y_next     = anchor_y_reg;
        prior_touch_next  = prior_touch_reg;
        last_click_next   = last_click_reg;
        if (pop)
        begin
            prior_touch_next = head_flags.touch;
            if (!head_flags.touch)
            begin
                anchor_valid_next = 1'b0;
            end
            else if (emit || !anchor_valid_reg)
            begin
                anchor_valid_next = 1'b1;
                anchor_x_next     = head_x;
                anchor_y_next     = head_y;
            end
            if (emit)
            begin
                last_click_next = head_flags.click;
            end
        end
        out_valid_next = load | (out_valid_reg & report_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anchor_valid_reg <= 1'b0;
            anchor_x_reg     <= '0;
            anchor_y_reg     <= '0;
            prior_touch_reg  <= 1'b0;
            last_click_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            anchor_valid_reg <= anchor_valid_next;
            anchor_x_reg     <= anchor_x_next;
            anchor_y_reg     <= anchor_y_next;
            prior_touch_reg  <= prior_touch_next;
            last_click_reg   <= last_click_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_button_reg <= head_flags.click;
            out_dx_reg     <= dx;
            out_dy_reg     <= dy;
        end
    end

    assign report_valid = out_valid_reg;
    assign button_state = out_button_reg;
    assign delta_x      = out_dx_reg;
    assign delta_y      = out_dy_reg;

endmodule

`default_nettype wire

// File: hdl/touchpad_to_relative_mouse.sv
// touchpad_to_relative_mouse: top level, config register, queue and assertions
// depends on tprm_pkg, tprm_front, tprm_queue, tprm_back
//
// usage:
//   point channel: point_valid / point_stall carry point0_raw, point1_raw,
//   click and host_ready; a transaction completes when valid is high and
//   stall low. report channel: report_valid / report_stall carry
//   button_state, delta_x and delta_y, zero or one report per point.
//   max_delta is written through max_delta_we / max_delta_wdata while idle.
// path: a taken point goes into a queue entry, then into the output
//   register; report_valid rises once its report is loaded there
// throughput: one point per cycle while point_stall is low; the back end
//   updates its anchor on the pop, so points with no report never wait
// stall: point_stall rises only when the two-entry queue is full, which
//   happens once the output register is held by report_stall and the
//   next queued point wants to report
// reset: anchor, touch history, last click and queue cleared, max_delta 127
`default_nettype none

module touchpad_to_relative_mouse #(
    parameter int unsigned COORD_BITS = 12
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 max_delta_we,
    input  wire logic        [tprm_pkg::LIMIT_BITS-1:0] max_delta_wdata,
    input  wire logic                                 point_valid,
    output logic                                      point_stall,
    input  wire logic        [31:0]                   point0_raw,
    input  wire logic        [31:0]                   point1_raw,
    input  wire logic                                 click,
    input  wire logic                                 host_ready,
    output logic                                      report_valid,
    input  wire logic                                 report_stall,
    output logic                                      button_state,
    output logic signed      [tprm_pkg::DELTA_BITS-1:0] delta_x,
    output logic signed      [tprm_pkg::DELTA_BITS-1:0] delta_y
);

    localparam int unsigned FLAG_BITS = $bits(tprm_pkg::point_flags_t);
    localparam int unsigned Q_BITS    = 2 * COORD_BITS + FLAG_BITS;

    logic [tprm_pkg::LIMIT_BITS-1:0] max_delta_reg;
    logic [tprm_pkg::LIMIT_BITS-1:0] max_delta_next;

    tprm_pkg::point_flags_t  front_flags;
    logic [COORD_BITS-1:0]   front_x;
    logic [COORD_BITS-1:0]   front_y;

    logic                    q_push;
    logic                    q_pop;
    logic                    q_full;
    logic                    q_head_valid;
    logic [Q_BITS-1:0]       q_head_data;
    logic [1:0]              q_count;

    tprm_pkg::point_flags_t  head_flags;
    logic [COORD_BITS-1:0]   head_x;
    logic [COORD_BITS-1:0]   head_y;

    assign max_delta_next = max_delta_we ? max_delta_wdata : max_delta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_delta_reg <= tprm_pkg::LIMIT_RESET;
        end
        else
        begin
            max_delta_reg <= max_delta_next;
        end
    end

    tprm_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .point0_raw (point0_raw),
        .point1_raw (point1_raw),
        .click      (click),
        .host_ready (host_ready),
        .flags      (front_flags),
        .pos_x      (front_x),
        .pos_y      (front_y)
    );

    assign point_stall = q_full;
    assign q_push      = point_valid & ~q_full;

    tprm_queue #(
        .DATA_BITS (Q_BITS)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  ({front_flags, front_x, front_y}),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_data  (q_head_data),
        .count      (q_count)
    );

    assign head_flags = tprm_pkg::point_flags_t'(q_head_data[Q_BITS-1 -: FLAG_BITS]);
    assign head_x     = q_head_data[COORD_BITS +: COORD_BITS];
    assign head_y     = q_head_data[COORD_BITS-1:0];

    tprm_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .max_delta    (max_delta_reg),
        .head_valid   (q_head_valid),
        .head_flags   (head_flags),
        .head_x       (head_x),
        .head_y       (head_y),
        .pop          (q_pop),
        .report_valid (report_valid),
        .report_stall (report_stall),
        .button_state (button_state),
        .delta_x      (delta_x),
        .delta_y      (delta_y)
    );

    // queue never holds more than its two entries
    assert property (@(posedge clk) disable iff (!rst_n) q_count != 2'd3)
        else $error("queue count out of range");

    // a taken point is in the queue on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) q_push |=> q_count != 2'd0)
        else $error("accepted point lost from queue");

    // reported deltas stay inside the saturation limit
    assert property (@(posedge clk) disable iff (!rst_n)
        report_valid |->
            (delta_x <= $signed({1'b0, max_delta_reg})) &&
            (delta_x >= -$signed({1'b0, max_delta_reg})) &&
            (delta_y <= $signed({1'b0, max_delta_reg})) &&
            (delta_y >= -$signed({1'b0, max_delta_reg})))
        else $error("delta outside saturation limit");

endmodule

`default_nettype wire
